// File: rtl/lep_pkg.sv
// Shared types and constants for the lower envelope peak finder.
// No dependencies.
package lep_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRAC_BITS     = 16;
    localparam int POS_W         = FRAC_BITS + 1;
    localparam int MAX_LINES_DEF = 64;

    // One incoming line
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] left_value;
        logic signed [VALUE_WIDTH-1:0] right_value;
        logic                          last_line;
    } t_line_in;

    // One search result
    typedef struct packed {
        logic [POS_W-1:0] peak_position;
        logic             overflow;
    } t_peak_out;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic idx_clr;
        logic idx_inc;
        logic min_cmp;
        logic best_init;
        logic div_start;
        logic div_step;
        logic scan_take;
        logic step_end;
        logic finish;
        logic finish_one;
    } t_lep_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic idx_last;
        logic rises;
        logic cand;
        logic div_done;
        logic q_valid;
    } t_lep_sts;

endpackage

// File: rtl/lep_datapath.sv
// Datapath: line stores, pivot and best-crossing registers, bit-serial divider.
// Depends on lep_pkg.
module lep_datapath #(
    parameter int MAX_LINES = lep_pkg::MAX_LINES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lep_pkg::t_line_in i_line,
    input  lep_pkg::t_lep_cmd i_cmd,
    output lep_pkg::t_lep_sts o_sts,
    output lep_pkg::t_peak_out o_peak
);
    import lep_pkg::*;

    localparam int IW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int SW = VALUE_WIDTH + 1;
    localparam int DW = VALUE_WIDTH + 2;
    localparam int RW = VALUE_WIDTH + 3;
    localparam int KW = $clog2(FRAC_BITS + 1);
    localparam logic [POS_W-1:0] ONE = POS_W'(1) << FRAC_BITS;

    logic signed [VALUE_WIDTH-1:0] r_mem_l [MAX_LINES];
    logic signed [VALUE_WIDTH-1:0] r_mem_r [MAX_LINES];
    logic signed [VALUE_WIDTH-1:0] r_rd_l, r_rd_r;
    logic signed [VALUE_WIDTH-1:0] r_lp, r_rp, r_ql, r_qr;
    logic signed [SW-1:0]          r_best_slope;
    logic [CW-1:0]                 r_count;
    logic [IW-1:0]                 r_idx;
    logic                          r_ovf;
    logic                          r_q_valid;
    logic [POS_W-1:0]              r_pos, r_best;
    logic [RW-1:0]                 r_rem;
    logic [DW-1:0]                 r_den;
    logic [FRAC_BITS-1:0]          r_q;
    logic [KW-1:0]                 r_cnt;
    t_peak_out                     r_out;

    logic signed [SW-1:0] slope_rd, slope_p, diff_a, diff_b;
    logic [DW-1:0]        den;
    logic [RW-1:0]        rem_sh;
    logic                 min_take, scan_take;

    // Slopes and crossing terms of the entry read against the pivot
    assign slope_rd = SW'(r_rd_r) - SW'(r_rd_l);
    assign slope_p  = SW'(r_rp) - SW'(r_lp);
    assign diff_a   = SW'(r_rd_l) - SW'(r_lp);
    assign diff_b   = SW'(r_rp) - SW'(r_rd_r);
    assign den      = DW'(unsigned'(diff_a)) + DW'(unsigned'(diff_b));
    assign rem_sh   = {r_rem[RW-2:0], 1'b0};

    assign min_take = (r_idx == '0) || (r_rd_l < r_lp) ||
                      ((r_rd_l == r_lp) && (slope_rd < slope_p));
    assign scan_take = (r_pos < {1'b0, r_q}) &&
                       (({1'b0, r_q} < r_best) ||
                        (({1'b0, r_q} == r_best) && r_q_valid &&
                         (slope_rd < r_best_slope)));

    assign o_sts.idx_last = (CW'(r_idx) == CW'(r_count - CW'(1)));
    assign o_sts.rises    = (r_rp > r_lp);
    assign o_sts.cand     = (r_rd_r < r_rp) && (r_rd_l > r_lp);
    assign o_sts.div_done = (r_cnt == KW'(FRAC_BITS));
    assign o_sts.q_valid  = r_q_valid;
    assign o_peak         = r_out;

    // Line store: write on load, read the current index every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_count < CW'(MAX_LINES))) begin
            r_mem_l[r_count[IW-1:0]] <= i_line.left_value;
            r_mem_r[r_count[IW-1:0]] <= i_line.right_value;
        end
        r_rd_l <= r_mem_l[r_idx];
        r_rd_r <= r_mem_r[r_idx];
    end

    // Control counters and flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_idx     <= '0;
            r_q_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (r_count < CW'(MAX_LINES)) begin
                    r_count <= r_count + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.best_init) begin
                r_q_valid <= 1'b0;
            end else if (i_cmd.scan_take && scan_take) begin
                r_q_valid <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // Pivot, best crossing, divider and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_line.last_line) begin
            r_pos <= '0;
        end
        if (i_cmd.min_cmp && min_take) begin
            r_lp <= r_rd_l;
            r_rp <= r_rd_r;
        end
        if (i_cmd.best_init) begin
            r_best <= ONE;
        end
        if (i_cmd.scan_take && scan_take) begin
            r_best       <= {1'b0, r_q};
            r_best_slope <= slope_rd;
            r_ql         <= r_rd_l;
            r_qr         <= r_rd_r;
        end
        if (i_cmd.step_end) begin
            r_lp  <= r_ql;
            r_rp  <= r_qr;
            r_pos <= r_best;
        end
        // restoring divide, one quotient bit a cycle
        if (i_cmd.div_start) begin
            r_rem <= RW'(unsigned'(diff_a));
            r_den <= den;
            r_q   <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            if (rem_sh >= RW'(r_den)) begin
                r_rem <= rem_sh - RW'(r_den);
                r_q   <= {r_q[FRAC_BITS-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q   <= {r_q[FRAC_BITS-2:0], 1'b0};
            end
            r_cnt <= r_cnt + KW'(1);
        end
        if (i_cmd.finish) begin
            r_out.peak_position <= i_cmd.finish_one ? ONE : r_pos;
            r_out.overflow      <= r_ovf;
        end
    end

endmodule

// File: rtl/lep_ctrl.sv
// Controller: sequences loading, the minimum pass and the pivot walk.
// Depends on lep_pkg.
module lep_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_last_line,
    input  lep_pkg::t_lep_sts i_sts,
    output lep_pkg::t_lep_cmd o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    import lep_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MIN_RD, S_MIN_CMP, S_PIV_CHK, S_SCAN_RD,
        S_SCAN_CHK, S_DIV, S_SCAN_TAKE, S_STEP_END
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy, r_done, n_done;
    logic   accept;

    assign accept = i_start && !r_busy;
    assign o_busy = r_busy;
    assign o_done = r_done;

    // Decode commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    if (i_last_line) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_MIN_RD;
                    end
                end
            end
            S_MIN_RD: n_state = S_MIN_CMP;
            S_MIN_CMP: begin
                o_cmd.min_cmp = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_PIV_CHK;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_MIN_RD;
                end
            end
            S_PIV_CHK: begin
                if (!i_sts.rises) begin
                    o_cmd.finish = 1'b1;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.idx_clr   = 1'b1;
                    o_cmd.best_init = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (i_sts.cand) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (i_sts.idx_last) begin
                    n_state = S_STEP_END;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_SCAN_TAKE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_SCAN_TAKE: begin
                o_cmd.scan_take = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_STEP_END;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_STEP_END: begin
                if (!i_sts.q_valid) begin
                    o_cmd.finish     = 1'b1;
                    o_cmd.finish_one = 1'b1;
                    n_done           = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.step_end = 1'b1;
                    n_state        = S_PIV_CHK;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_busy = (n_state != S_IDLE);
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("result strobe while busy");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("result strobe repeated");
    a_plain_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_last_line) |=> (!r_busy && !r_done))
        else $error("non-final line started a search");
    a_final_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_line) |=> r_busy) else $error("final line not searched");
`endif

endmodule

// File: rtl/lower_envelope_peak_finder.sv
// Lines load at one transaction per cycle while busy is low; a non-final line leaves it low.
// A final line starts the search: a minimum pass reads and compares every stored line, then
// each pivot step scans the lines and runs the bit-serial divider for each crossing.
// The result shows on o_peak with o_done high for one cycle; the receiver cannot stall.
// Synchronous active-low reset clears the controller and the line count; stores are not cleared.
module lower_envelope_peak_finder #(
    parameter int MAX_LINES = lep_pkg::MAX_LINES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  lep_pkg::t_line_in  i_line,
    output logic               o_done,
    output lep_pkg::t_peak_out o_peak
);
    import lep_pkg::*;

    t_lep_cmd cmd;
    t_lep_sts sts;

    lep_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_last_line (i_line.last_line),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_busy      (busy),
        .o_done      (o_done)
    );

    lep_datapath #(
        .MAX_LINES (MAX_LINES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (i_line),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_peak  (o_peak)
    );

endmodule
